/* rtl/lcd_mt_pkg.sv */
// Package for the LCD scanline mode timing core: payload structs, mode and
// operation codes, and timing constants. No dependencies.
`default_nettype none

package lcd_mt_pkg;

   typedef enum logic [1:0] {
      MODE_HBLANK   = 2'd0,
      MODE_VBLANK   = 2'd1,
      MODE_SEARCH   = 2'd2,
      MODE_TRANSFER = 2'd3
   } ppu_mode_type;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_WR_CTRL   = 2'd1,
      OP_WR_STAT   = 2'd2,
      OP_RESERVED  = 2'd3
   } op_type;

   localparam logic [9:0] ACC_MAX        = 10'd1023;
   localparam logic [9:0] SEARCH_CYCLES  = 10'd80;
   localparam logic [9:0] XFER_CYCLES    = 10'd172;
   localparam logic [9:0] HBLANK_CYCLES  = 10'd204;
   localparam logic [9:0] LINE_CYCLES    = 10'd456;
   localparam logic [7:0] VBLANK_LINE    = 8'd144;
   localparam logic [7:0] LAST_LINE      = 8'd153;
   localparam int unsigned CTRL_ON_BIT   = 7;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] tick_cycles;
      logic [7:0] write_data;
      logic [7:0] compare_line;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] stat_value;
      logic [7:0] line_number;
      logic [1:0] ppu_mode;
      logic       stat_interrupt;
      logic       vblank_interrupt;
      logic       render_request;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* rtl/lcd_mode_timing_and_stat_irq_core.sv */
// LCD scanline mode timing and STAT interrupt core, top level.
// Depends on lcd_mt_pkg for payload structs, codes and timing constants.
//
// Usage:
//   req_* carries one item: a tick of elapsed cycles, a control byte write or
//   a status enable write. Each accepted item yields exactly one rsp_* item
//   with the status byte, line, mode and the three event flags after it.
//   An item is transferred when valid and ready are both high.
//   The state update and the result are computed combinationally from the
//   request payload and the current state, and the result is captured in
//   the output register at the transfer edge.
//   Throughput is one item per cycle; req_ready is high while the output
//   register is empty or being drained in the same cycle, so a new item is
//   taken while the previous result is being transferred.
//   If the receiver stalls, the result holds in the output register and
//   req_ready drops until it is taken; no item is lost.
//   Reset (synchronous, active high) sets search mode, line 0, an empty
//   cycle accumulator, the display on, all enables clear and the output
//   register empty.
`default_nettype none

module lcd_mode_timing_and_stat_irq_core
   import lcd_mt_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      rsp_payload_type rsp_payload
);

   ppu_mode_type    mode_ff, mode_in;
   logic [7:0]      line_ff, line_in;
   logic [9:0]      acc_ff, acc_in;
   logic            display_on_ff, display_on_in;
   logic [3:0]      enables_ff, enables_in;
   logic            prev_irq_ff, prev_irq_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            accept;
   logic [10:0]     acc_sum;
   logic [9:0]      acc_sat;
   logic [7:0]      line_inc;
   logic            transition;
   logic            render_hit;
   logic            vblank_hit;
   logic            coincide;
   logic            irq_level;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign acc_sum  = {1'b0, acc_ff} + {3'b000, req_payload.tick_cycles};
   assign acc_sat  = acc_sum[10] ? ACC_MAX : acc_sum[9:0];
   assign line_inc = line_ff + 8'd1;

   // Next-state logic for the timing sequencer
   always_comb begin
      mode_in       = mode_ff;
      line_in       = line_ff;
      acc_in        = acc_ff;
      display_on_in = display_on_ff;
      enables_in    = enables_ff;
      transition    = 1'b0;
      render_hit    = 1'b0;
      vblank_hit    = 1'b0;
      unique case (op_type'(req_payload.op))
         OP_TICK: begin
            if (display_on_ff) begin
               acc_in = acc_sat;
               unique case (mode_ff)
                  MODE_SEARCH: begin
                     if (acc_sat >= SEARCH_CYCLES) begin
                        acc_in     = acc_sat - SEARCH_CYCLES;
                        mode_in    = MODE_TRANSFER;
                        transition = 1'b1;
                     end
                  end
                  MODE_TRANSFER: begin
                     if (acc_sat >= XFER_CYCLES) begin
                        acc_in     = acc_sat - XFER_CYCLES;
                        mode_in    = MODE_HBLANK;
                        render_hit = 1'b1;
                        transition = 1'b1;
                     end
                  end
                  MODE_HBLANK: begin
                     if (acc_sat >= HBLANK_CYCLES) begin
                        acc_in     = acc_sat - HBLANK_CYCLES;
                        line_in    = line_inc;
                        transition = 1'b1;
                        if (line_inc == VBLANK_LINE) begin
                           mode_in    = MODE_VBLANK;
                           vblank_hit = 1'b1;
                        end else begin
                           mode_in = MODE_SEARCH;
                        end
                     end
                  end
                  MODE_VBLANK: begin
                     if (acc_sat >= LINE_CYCLES) begin
                        acc_in     = acc_sat - LINE_CYCLES;
                        line_in    = line_inc;
                        transition = 1'b1;
                        if (line_inc > LAST_LINE) begin
                           line_in = 8'd0;
                           mode_in = MODE_SEARCH;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         OP_WR_CTRL: begin
            display_on_in = req_payload.write_data[CTRL_ON_BIT];
            // Switching the display off parks the sequencer in hblank
            if (display_on_ff && !req_payload.write_data[CTRL_ON_BIT]) begin
               line_in = 8'd0;
               acc_in  = 10'd0;
               mode_in = MODE_HBLANK;
            end
         end
         OP_WR_STAT: begin
            enables_in = req_payload.write_data[6:3];
         end
         default: ;
      endcase
   end

   // Result and interrupt source evaluation on the updated state
   always_comb begin
      coincide  = (line_in == req_payload.compare_line);
      irq_level = (enables_in[3] && coincide)
               || (enables_in[2] && (mode_in == MODE_SEARCH))
               || (enables_in[1] && (mode_in == MODE_VBLANK))
               || (enables_in[0] && (mode_in == MODE_HBLANK));
      // The source line is only sampled on a mode or line transition
      prev_irq_in = transition ? irq_level : prev_irq_ff;

      rsp_payload_in.stat_value       = {1'b1, enables_in, coincide, mode_in};
      rsp_payload_in.line_number      = line_in;
      rsp_payload_in.ppu_mode         = mode_in;
      rsp_payload_in.stat_interrupt   = transition && irq_level && !prev_irq_ff;
      rsp_payload_in.vblank_interrupt = vblank_hit;
      rsp_payload_in.render_request   = render_hit;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SEARCH;
         line_ff       <= 8'd0;
         acc_ff        <= 10'd0;
         display_on_ff <= 1'b1;
         enables_ff    <= 4'd0;
         prev_irq_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff       <= mode_in;
            line_ff       <= line_in;
            acc_ff        <= acc_in;
            display_on_ff <= display_on_in;
            enables_ff    <= enables_in;
            prev_irq_ff   <= prev_irq_in;
         end
      end
   end

   // Hold the result until its transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* verif/lcd_mode_timing_and_stat_irq_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lcd_mode_timing_and_stat_irq_core: scanline timing,
// STAT edge detection, vblank entry and display-off handling against a local predictor.
// Depends on lcd_mt_pkg and the core RTL only.

module lcd_mode_timing_and_stat_irq_core_tb;
   import lcd_mt_pkg::*;

   localparam int RUN_LIMIT    = 200000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_PCT     = 27;
   localparam int CALM_FROM    = 600;
   localparam int CALM_TO      = 1300;

   typedef struct packed {
      ppu_mode_type mode;
      logic [7:0]   line;
      logic [9:0]   acc;
      logic [7:0]   ctrl;
      logic [3:0]   enables;
      logic         irq_level;
   } scan_state_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   req_payload_type req_backlog[$];
   rsp_payload_type status_expected[$];
   scan_state_type  gen_scan;
   scan_state_type  model_scan;
   int              mismatch_count = 0;
   int              cycle_count = 0;

   lcd_mode_timing_and_stat_irq_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic scan_state_type scan_after_reset();
      scan_state_type st;
      st.mode      = MODE_SEARCH;
      st.line      = 8'd0;
      st.acc       = 10'd0;
      st.ctrl      = 8'h91;
      st.enables   = 4'd0;
      st.irq_level = 1'b0;
      return st;
   endfunction

   // Apply one item to the scanline state and return the status it reports.
   function automatic rsp_payload_type advance_scanline(inout scan_state_type st,
                                                        input req_payload_type rq);
      rsp_payload_type rs;
      logic [10:0]     sum;
      logic            moved;
      logic            coinc;
      logic            level;
      rs    = '0;
      moved = 1'b0;
      case (op_type'(rq.op))
         OP_TICK: begin
            if (st.ctrl[CTRL_ON_BIT]) begin
               sum    = {1'b0, st.acc} + {3'b000, rq.tick_cycles};
               st.acc = (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[9:0];
               case (st.mode)
                  MODE_SEARCH: begin
                     if (st.acc >= SEARCH_CYCLES) begin
                        st.acc  = st.acc - SEARCH_CYCLES;
                        st.mode = MODE_TRANSFER;
                        moved   = 1'b1;
                     end
                  end
                  MODE_TRANSFER: begin
                     if (st.acc >= XFER_CYCLES) begin
                        st.acc            = st.acc - XFER_CYCLES;
                        st.mode           = MODE_HBLANK;
                        rs.render_request = 1'b1;
                        moved             = 1'b1;
                     end
                  end
                  MODE_HBLANK: begin
                     if (st.acc >= HBLANK_CYCLES) begin
                        st.acc  = st.acc - HBLANK_CYCLES;
                        st.line = st.line + 8'd1;
                        if (st.line == VBLANK_LINE) begin
                           st.mode             = MODE_VBLANK;
                           rs.vblank_interrupt = 1'b1;
                        end else begin
                           st.mode = MODE_SEARCH;
                        end
                        moved = 1'b1;
                     end
                  end
                  default: begin
                     if (st.acc >= LINE_CYCLES) begin
                        st.acc  = st.acc - LINE_CYCLES;
                        st.line = st.line + 8'd1;
                        if (st.line > LAST_LINE) begin
                           st.line = 8'd0;
                           st.mode = MODE_SEARCH;
                        end
                        moved = 1'b1;
                     end
                  end
               endcase
            end
         end
         OP_WR_CTRL: begin
            // switching the display off parks the sequencer; the irq level is kept
            if (st.ctrl[CTRL_ON_BIT] && !rq.write_data[CTRL_ON_BIT]) begin
               st.line = 8'd0;
               st.acc  = 10'd0;
               st.mode = MODE_HBLANK;
            end
            st.ctrl = rq.write_data;
         end
         OP_WR_STAT: st.enables = rq.write_data[6:3];
         default: ;
      endcase
      coinc = (st.line == rq.compare_line);
      if (moved) begin
         level = (st.enables[3] && coinc) ||
                 (st.enables[2] && st.mode == MODE_SEARCH) ||
                 (st.enables[1] && st.mode == MODE_VBLANK) ||
                 (st.enables[0] && st.mode == MODE_HBLANK);
         rs.stat_interrupt = level && !st.irq_level;
         st.irq_level      = level;
      end
      rs.stat_value  = {1'b1, st.enables, coinc, st.mode};
      rs.line_number = st.line;
      rs.ppu_mode    = st.mode;
      return rs;
   endfunction

   task automatic queue_item(input op_type op, input logic [7:0] cyc,
                             input logic [7:0] data, input logic [7:0] cmp);
      req_payload_type rq;
      rq.op           = op;
      rq.tick_cycles  = cyc;
      rq.write_data   = data;
      rq.compare_line = cmp;
      void'(advance_scanline(gen_scan, rq));
      req_backlog.push_back(rq);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   function automatic logic calm_now();
      return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
   endfunction

   // Driver: predict on each transfer, then present the next item or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            status_expected.push_back(advance_scanline(model_scan, req_payload));
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 && (calm_now() || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid   <= 1'b1;
               req_payload <= req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transfer against the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_expected.size() == 0) begin
               $error("unexpected result transfer: %h", rsp_payload);
               mismatch_count++;
            end else begin
               want = status_expected.pop_front();
               check_field("stat_value", want.stat_value, rsp_payload.stat_value);
               check_field("line_number", want.line_number, rsp_payload.line_number);
               check_field("ppu_mode", {6'd0, want.ppu_mode}, {6'd0, rsp_payload.ppu_mode});
               check_field("stat_interrupt", {7'd0, want.stat_interrupt},
                           {7'd0, rsp_payload.stat_interrupt});
               check_field("vblank_interrupt", {7'd0, want.vblank_interrupt},
                           {7'd0, rsp_payload.vblank_interrupt});
               check_field("render_request", {7'd0, want.render_request},
                           {7'd0, rsp_payload.render_request});
            end
         end
         rsp_ready <= calm_now() || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("lcd_mode_timing_and_stat_irq_core_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int         n;
      int         pick;
      logic [7:0] cyc;
      logic [7:0] data;
      logic [7:0] cmp;
      gen_scan   = scan_after_reset();
      model_scan = scan_after_reset();

      // directed: reserved op, enables, full path to saturation, display off and on
      queue_item(OP_RESERVED, 8'hFF, 8'hFF, 8'hFF);
      queue_item(OP_WR_STAT, 8'h00, 8'hFF, 8'h00);
      queue_item(OP_TICK, 8'h00, 8'h00, 8'h00);
      queue_item(OP_TICK, 8'hFF, 8'h00, 8'h00);
      queue_item(OP_TICK, 8'hFF, 8'h00, 8'h00);
      queue_item(OP_TICK, 8'hFF, 8'h00, 8'h01);
      queue_item(OP_TICK, 8'hFF, 8'h00, 8'h01);
      queue_item(OP_TICK, 8'hFF, 8'h00, 8'h05);
      queue_item(OP_TICK, 8'hFF, 8'h00, 8'h02);
      queue_item(OP_TICK, 8'hFF, 8'h00, 8'h02);
      queue_item(OP_TICK, 8'hFF, 8'h00, 8'hFF);
      queue_item(OP_WR_STAT, 8'hFF, 8'h00, 8'h02);
      queue_item(OP_WR_CTRL, 8'h00, 8'h7F, 8'h00);
      queue_item(OP_TICK, 8'hFF, 8'h00, 8'h00);
      queue_item(OP_WR_CTRL, 8'h00, 8'h00, 8'h00);
      queue_item(OP_WR_CTRL, 8'h00, 8'hFF, 8'h00);
      queue_item(OP_WR_STAT, 8'h00, 8'h40, 8'h01);
      queue_item(OP_TICK, 8'd204, 8'h00, 8'h01);
      queue_item(OP_RESERVED, 8'hFF, 8'h00, 8'h00);

      // random: mostly ticks so that frames run through vblank and wrap
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 999);
         cyc  = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(128, 255)) : 8'($urandom);
         data = 8'($urandom);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: cmp = gen_scan.line;
            8, 9, 10:               cmp = gen_scan.line + 8'd1;
            default:                cmp = 8'($urandom);
         endcase
         if (pick < 880) begin
            queue_item(OP_TICK, cyc, data, cmp);
         end else if (pick < 930) begin
            queue_item(OP_WR_STAT, cyc, data, cmp);
         end else if (pick < 985) begin
            // keep the display mostly on; an off write is rare and soon undone
            if (gen_scan.ctrl[CTRL_ON_BIT])
               data[CTRL_ON_BIT] = ($urandom_range(0, 24) != 0);
            else
               data[CTRL_ON_BIT] = ($urandom_range(0, 3) != 0);
            queue_item(OP_WR_CTRL, cyc, data, cmp);
         end else begin
            queue_item(OP_RESERVED, cyc, data, cmp);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid || status_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("lcd_mode_timing_and_stat_irq_core_tb: done, clean");
      else
         $display("lcd_mode_timing_and_stat_irq_core_tb: done, errors");
      $finish;
   end

endmodule
